// ----- rtl/ltcq_pkg.sv -----
// Shared types and constants for the LOUDS tree child query block.
`default_nettype none
package ltcq_pkg;

   localparam int MAX_NODES  = 64;
   localparam int STORE_BITS = 2 * MAX_NODES + 1;
   localparam int WORD_BITS  = 8;
   localparam int WORD_LOG   = 3;
   localparam int NUM_WORDS  = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int POS_W      = $clog2(STORE_BITS + 1);
   localparam int CNT_W      = $clog2(MAX_NODES + 1);
   localparam int OP_W       = 2;
   localparam int FIELD_W    = 6;
   localparam int STATUS_W   = 2;
   localparam int SUM_W      = ((POS_W > FIELD_W) ? POS_W : FIELD_W) + 1;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_LIST   = 2'd1,
      OP_TEST   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NOT_LOADED = 2'd1,
      ST_FULL       = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FIELD_W-1:0] node_index;
      logic [FIELD_W-1:0] degree;
      logic [FIELD_W-1:0] other_index;
   } ltcq_item_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] child_index;
      logic               has_child;
      logic               is_child;
      logic               is_last;
   } ltcq_res_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] data;
   } ltcq_wr_type;

endpackage
`default_nettype wire

// ----- rtl/ltcq_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface ltcq_req_if;
   import ltcq_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FIELD_W-1:0] node_index;
   logic [FIELD_W-1:0] degree;
   logic [FIELD_W-1:0] other_index;
   modport source (output valid, operation, node_index, degree, other_index, input ready);
   modport sink   (input valid, operation, node_index, degree, other_index, output ready);
endinterface

interface ltcq_rsp_if;
   import ltcq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  child_index;
   logic                has_child;
   logic                is_child;
   logic                is_last;
   modport source (output valid, status, child_index, has_child, is_child, is_last,
                   input ready);
   modport sink   (input valid, status, child_index, has_child, is_child, is_last,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/ltcq_store.sv -----
// Degree bit store: word memory, one read and one write port, per-word valid bits.
`default_nettype none
module ltcq_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ltcq_pkg::ltcq_wr_type         wr,
   input  wire logic [ltcq_pkg::ADDR_W-1:0]   rd_addr,
   output logic [ltcq_pkg::WORD_BITS-1:0]     rd_word
);
   import ltcq_pkg::*;

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_zero_ff  <= (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // unwritten words read as the reset image: super-root one in bit 0
   assign rd_word = rd_valid_ff ? rd_data_ff :
                    (rd_zero_ff ? WORD_BITS'(1) : '0);

endmodule
`default_nettype wire

// ----- rtl/ltcq_engine.sv -----
// Append, select/rank scan and child walk sequencer over the bit store.
`default_nettype none
module ltcq_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire ltcq_pkg::ltcq_item_type       item,
   output logic                               idle,
   input  wire logic                          out_free,
   output logic                               res_valid,
   output ltcq_pkg::ltcq_res_type             res,
   output ltcq_pkg::ltcq_wr_type              wr,
   output logic [ltcq_pkg::ADDR_W-1:0]        rd_addr,
   input  wire logic [ltcq_pkg::WORD_BITS-1:0] rd_word
);
   import ltcq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APP_WR,
      S_SCAN,
      S_CHILD,
      S_FINAL
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [FIELD_W-1:0] node_ff, node_in;
   logic [FIELD_W-1:0] deg_ff, deg_in;
   logic [FIELD_W-1:0] other_ff, other_in;
   logic [POS_W-1:0]   wp_ff, wp_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [POS_W-1:0]   zeros_ff, zeros_in;
   logic [POS_W-1:0]   ones_ff, ones_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   child_ff, child_in;
   logic [POS_W-1:0]   pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   status_type         status_ff, status_in;
   logic               found_ff, found_in;

   logic [SUM_W-1:0]     wp_s;
   logic [SUM_W-1:0]     end_s;
   logic [SUM_W-1:0]     base_s;
   logic [SUM_W-1:0]     p_s;
   logic [SUM_W-1:0]     target_s;
   logic [SUM_W-1:0]     z_s;
   logic [SUM_W-1:0]     o_s;
   logic [SUM_W-1:0]     hpos_s;
   logic [SUM_W-1:0]     hfirst_s;
   logic                 hit;
   logic [WORD_BITS-1:0] merged;
   logic                 last_word;
   logic                 word_end;
   logic                 is_full;
   logic                 is_one;
   logic [POS_W-1:0]     pos_next;

   assign wp_s     = SUM_W'(wp_ff);
   assign end_s    = wp_s + SUM_W'(deg_ff);
   assign base_s   = SUM_W'({addr_ff, WORD_LOG'(0)});
   assign target_s = SUM_W'(node_ff) + SUM_W'(1);
   assign last_word = (SUM_W'(addr_ff) == (end_s >> WORD_LOG));
   assign word_end  = (base_s + SUM_W'(WORD_BITS) >= wp_s);
   assign is_full   = (SUM_W'(loaded_ff) >= SUM_W'(MAX_NODES)) ||
                      (wp_s + SUM_W'(item.degree) + SUM_W'(1) > SUM_W'(STORE_BITS));
   assign is_one    = (pos_ff < wp_ff) && (SUM_W'(pos_ff) < SUM_W'(STORE_BITS)) &&
                      rd_word[pos_ff[WORD_LOG-1:0]];
   assign pos_next  = pos_ff + POS_W'(1);
   assign idle      = (state_ff == S_IDLE);
   assign rd_addr   = addr_in;

   // new word image for an append: ones, then the terminating zero
   always_comb begin
      merged = rd_word;
      for (int j = 0; j < WORD_BITS; j++) begin
         p_s = SUM_W'({addr_ff, WORD_LOG'(j)});
         if (p_s >= wp_s && p_s < end_s) begin
            merged[j] = 1'b1;
         end else if (p_s == end_s) begin
            merged[j] = 1'b0;
         end
      end
   end

   // select within one word: position after the (node+1)th zero, ones before it
   always_comb begin
      z_s      = SUM_W'(zeros_ff);
      o_s      = SUM_W'(ones_ff);
      hit      = 1'b0;
      hpos_s   = '0;
      hfirst_s = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (!hit && (base_s + SUM_W'(j) < wp_s)) begin
            if (rd_word[j]) begin
               o_s = o_s + SUM_W'(1);
            end else begin
               z_s = z_s + SUM_W'(1);
               if (z_s == target_s) begin
                  hit      = 1'b1;
                  hpos_s   = base_s + SUM_W'(j) + SUM_W'(1);
                  hfirst_s = o_s;
               end
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      node_in       = node_ff;
      deg_in        = deg_ff;
      other_in      = other_ff;
      wp_in         = wp_ff;
      loaded_in     = loaded_ff;
      addr_in       = addr_ff;
      zeros_in      = zeros_ff;
      ones_in       = ones_ff;
      pos_in        = pos_ff;
      child_in      = child_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      wr            = '0;
      res_valid     = 1'b0;
      res           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(item.operation);
               node_in  = item.node_index;
               deg_in   = item.degree;
               other_in = item.other_index;
               found_in = 1'b0;
               case (op_type'(item.operation))
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                        state_in  = S_FINAL;
                     end else begin
                        addr_in  = ADDR_W'(wp_ff >> WORD_LOG);
                        state_in = S_APP_WR;
                     end
                  end
                  OP_LIST, OP_TEST: begin
                     if (SUM_W'(item.node_index) >= SUM_W'(loaded_ff)) begin
                        status_in = ST_NOT_LOADED;
                        state_in  = S_FINAL;
                     end else begin
                        status_in     = ST_OK;
                        addr_in       = '0;
                        zeros_in      = '0;
                        ones_in       = '0;
                        pend_valid_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_APP_WR: begin
            wr.en   = 1'b1;
            wr.addr = addr_ff;
            wr.data = merged;
            if (last_word) begin
               wp_in     = POS_W'(end_s + SUM_W'(1));
               loaded_in = loaded_ff + CNT_W'(1);
               status_in = ST_OK;
               state_in  = S_FINAL;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_SCAN: begin
            if (hit) begin
               pos_in   = POS_W'(hpos_s);
               child_in = POS_W'(hfirst_s);
               addr_in  = ADDR_W'(hpos_s >> WORD_LOG);
               state_in = S_CHILD;
            end else if (word_end) begin
               state_in = S_FINAL;
            end else begin
               zeros_in = POS_W'(z_s);
               ones_in  = POS_W'(o_s);
               addr_in  = addr_ff + ADDR_W'(1);
            end
         end
         S_CHILD: begin
            if (is_one) begin
               if (op_ff == OP_TEST) begin
                  found_in = found_ff | (child_ff == POS_W'(other_ff));
                  pos_in   = pos_next;
                  child_in = child_ff + POS_W'(1);
                  addr_in  = ADDR_W'(pos_next >> WORD_LOG);
               end else if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     res_valid         = 1'b1;
                     res.status        = ST_OK;
                     res.child_index   = pend_ff[FIELD_W-1:0];
                     res.has_child     = 1'b1;
                  end
                  pend_in       = child_ff;
                  pend_valid_in = 1'b1;
                  pos_in        = pos_next;
                  child_in      = child_ff + POS_W'(1);
                  addr_in       = ADDR_W'(pos_next >> WORD_LOG);
               end
            end else if (op_ff == OP_LIST && pend_valid_ff) begin
               if (out_free) begin
                  res_valid       = 1'b1;
                  res.status      = ST_OK;
                  res.child_index = pend_ff[FIELD_W-1:0];
                  res.has_child   = 1'b1;
                  res.is_last     = 1'b1;
                  pend_valid_in   = 1'b0;
                  state_in        = S_IDLE;
               end
            end else begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               res_valid    = 1'b1;
               res.status   = status_ff;
               res.is_child = found_ff;
               res.is_last  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wp_ff         <= POS_W'(2);
         loaded_ff     <= '0;
         pend_valid_ff <= 1'b0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         wp_ff         <= wp_in;
         loaded_ff     <= loaded_in;
         pend_valid_ff <= pend_valid_in;
         addr_ff       <= addr_in;
      end
      op_ff     <= op_in;
      node_ff   <= node_in;
      deg_ff    <= deg_in;
      other_ff  <= other_in;
      zeros_ff  <= zeros_in;
      ones_ff   <= ones_in;
      pos_ff    <= pos_in;
      child_ff  <= child_in;
      pend_ff   <= pend_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(wp_ff) <= SUM_W'(STORE_BITS))
      else $error("write position past store");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(loaded_ff) <= SUM_W'(MAX_NODES))
      else $error("node count past capacity");

   a_child_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHILD |-> SUM_W'(addr_ff) == (SUM_W'(pos_ff) >> WORD_LOG))
      else $error("child walk word out of step with position");

   a_write_above_wp: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> SUM_W'(wr.addr) >= (wp_s >> WORD_LOG))
      else $error("append overwrites committed words");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result pushed into a full output register");

endmodule
`default_nettype wire

// ----- rtl/louds_tree_child_query.sv -----
// Top level: LOUDS tree child query with request/response channels.
//
//   channel  dir  transfer
//   req_     in   operation, node_index, degree, other_index
//   rsp_     out  status, child_index, has_child, is_child, is_last
//
// One item at a time; the bit store is read one 8-bit word per cycle.
// Append: each touched word (1..9) is read and rewritten, then S_FINAL.
// Query: words scanned up to the node's terminator (1..17), one child bit
// per cycle through the closing zero, then S_FINAL for a relation test or
// a leaf. Unloaded index or full store: S_FINAL only. Reset: no sweep.
// A stalled response holds the walk; the next request is taken once the
// engine is idle, even while the last response waits.
`default_nettype none
module louds_tree_child_query (
   input  wire logic   clock,
   input  wire logic   reset,
   ltcq_req_if.sink    req_chan,
   ltcq_rsp_if.source  rsp_chan
);
   import ltcq_pkg::*;

   ltcq_item_type        item;
   ltcq_res_type         res;
   ltcq_wr_type          wr;
   logic                 idle;
   logic                 res_valid;
   logic                 out_free;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_word;
   logic                 rsp_valid_ff, rsp_valid_in;
   ltcq_res_type         rsp_ff, rsp_in;

   assign item.operation   = req_chan.operation;
   assign item.node_index  = req_chan.node_index;
   assign item.degree      = req_chan.degree;
   assign item.other_index = req_chan.other_index;
   assign req_chan.ready   = idle;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.child_index = rsp_ff.child_index;
   assign rsp_chan.has_child   = rsp_ff.has_child;
   assign rsp_chan.is_child    = rsp_ff.is_child;
   assign rsp_chan.is_last     = rsp_ff.is_last;

   ltcq_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .item      (item),
      .idle      (idle),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .rd_word   (rd_word)
   );

   ltcq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_word (rd_word)
   );

endmodule
`default_nettype wire

// ----- sim/tb_louds_tree_child_query.sv -----
// Testbench for louds_tree_child_query: directed table plus random requests vs a predictor.
`default_nettype none
module tb_louds_tree_child_query;
   import ltcq_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 290;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   localparam ltcq_res_type OK_LAST_RES = '{status: ST_OK, child_index: 6'd0,
      has_child: 1'b0, is_child: 1'b0, is_last: 1'b1};
   localparam ltcq_res_type NOT_LOADED_RES = '{status: ST_NOT_LOADED, child_index: 6'd0,
      has_child: 1'b0, is_child: 1'b0, is_last: 1'b1};
   localparam ltcq_res_type FULL_RES = '{status: ST_FULL, child_index: 6'd0,
      has_child: 1'b0, is_child: 1'b0, is_last: 1'b1};

   typedef struct packed {
      ltcq_item_type item;
      logic          typed;
      ltcq_res_type  want;
   } row_type;

   logic clock;
   logic reset = 1'b1;

   ltcq_req_if req_bus ();
   ltcq_rsp_if rsp_bus ();

   louds_tree_child_query dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // predictor state
   bit           tree_bits [STORE_BITS];
   int unsigned  nodes_in;
   int unsigned  wr_pos;
   ltcq_res_type child_results_due [$];

   int  fails = 0;
   int  responses_seen = 0;
   int  op_count [4];
   int  idle_pct = 0;
   bit  hold_req = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;
   row_type directed_rows [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Timeout at %0t with %0d responses outstanding", $time,
               child_results_due.size());
      $display("[louds_tree_child_query] ERROR");
      $finish;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
      return $urandom_range(1, 3);
   endfunction

   // select/rank: position after the (node+1)th zero and ones seen before it
   function automatic void locate_children(input int unsigned node,
                                           output int unsigned first,
                                           output int unsigned pos);
      int unsigned zeros;
      int unsigned ones;
      zeros = 0;
      ones = 0;
      pos = wr_pos;
      first = 0;
      for (int unsigned p = 0; p < wr_pos && p < STORE_BITS; p++) begin
         if (tree_bits[p]) begin
            ones++;
         end else begin
            zeros++;
            if (zeros == node + 1) begin
               first = ones;
               pos = p + 1;
               return;
            end
         end
      end
      first = ones;
   endfunction

   function automatic void apply_tree_op(input ltcq_item_type it, input bit keep);
      ltcq_res_type burst [$];
      ltcq_res_type r;
      ltcq_res_type pending;
      int unsigned  first;
      int unsigned  pos;
      int unsigned  child;
      int           count;
      bit           found;
      bit           have_pending;
      r = '0;
      r.is_last = 1'b1;
      case (it.operation)
         OP_APPEND: begin
            if (nodes_in >= MAX_NODES || wr_pos + it.degree + 1 > STORE_BITS) begin
               r.status = ST_FULL;
            end else begin
               for (int k = 0; k < it.degree; k++) tree_bits[wr_pos + k] = 1'b1;
               tree_bits[wr_pos + it.degree] = 1'b0;
               wr_pos += it.degree + 1;
               nodes_in++;
               r.status = ST_OK;
            end
            burst = {burst, r};
         end
         OP_LIST, OP_TEST: begin
            if (it.node_index >= nodes_in) begin
               r.status = ST_NOT_LOADED;
               burst = {burst, r};
            end else begin
               locate_children(it.node_index, first, pos);
               child = first;
               count = 0;
               found = 1'b0;
               have_pending = 1'b0;
               pending = '0;
               while (pos < wr_pos && pos < STORE_BITS && tree_bits[pos]) begin
                  if (it.operation == OP_LIST) begin
                     if (count < 63) begin
                        if (have_pending) burst = {burst, pending};
                        pending = '0;
                        pending.status = ST_OK;
                        pending.child_index = child[FIELD_W-1:0];
                        pending.has_child = 1'b1;
                        have_pending = 1'b1;
                        count++;
                     end
                  end else if (child == it.other_index) begin
                     found = 1'b1;
                  end
                  child++;
                  pos++;
               end
               if (it.operation == OP_TEST) begin
                  r.status = ST_OK;
                  r.is_child = found;
                  burst = {burst, r};
               end else if (have_pending) begin
                  pending.is_last = 1'b1;
                  burst = {burst, pending};
               end else begin
                  r.status = ST_OK;
                  burst = {burst, r};
               end
            end
         end
         default: ;
      endcase
      if (keep) begin
         child_results_due = {child_results_due, burst};
      end
   endfunction

   function automatic row_type make_row(input logic [OP_W-1:0] op,
                                        input logic [FIELD_W-1:0] node,
                                        input logic [FIELD_W-1:0] deg,
                                        input logic [FIELD_W-1:0] other,
                                        input logic typed,
                                        input ltcq_res_type want);
      row_type row;
      row.item.operation = op;
      row.item.node_index = node;
      row.item.degree = deg;
      row.item.other_index = other;
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic void add_row(input row_type row);
      directed_rows = {directed_rows, row};
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic send_item(input ltcq_item_type it, input logic typed,
                            input ltcq_res_type want);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.operation   <= it.operation;
      req_bus.node_index  <= it.node_index;
      req_bus.degree      <= it.degree;
      req_bus.other_index <= it.other_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_tree_op(it, !typed);
      if (typed) child_results_due = {child_results_due, want};
      op_count[it.operation]++;
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // response side: random stalls, one long hold-off, checking
   initial begin : response_side
      ltcq_res_type got;
      ltcq_res_type want;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = gap_len();
         end
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            responses_seen++;
            got.status      = status_type'(rsp_bus.status);
            got.child_index = rsp_bus.child_index;
            got.has_child   = rsp_bus.has_child;
            got.is_child    = rsp_bus.is_child;
            got.is_last     = rsp_bus.is_last;
            if (child_results_due.size() == 0) begin
               fails++;
               $display("%0t: unexpected transfer st=%0d child=%0d has=%0d is=%0d last=%0d",
                        $time, got.status, got.child_index, got.has_child,
                        got.is_child, got.is_last);
            end else begin
               want = child_results_due.pop_front();
               if (got.status !== want.status || got.child_index !== want.child_index ||
                   got.has_child !== want.has_child || got.is_child !== want.is_child ||
                   got.is_last !== want.is_last) begin
                  fails++;
                  $display("%0t: mismatch exp st=%0d child=%0d has=%0d is=%0d last=%0d, %s",
                           $time, want.status, want.child_index, want.has_child,
                           want.is_child, want.is_last,
                           $sformatf("got st=%0d child=%0d has=%0d is=%0d last=%0d",
                                     got.status, got.child_index, got.has_child,
                                     got.is_child, got.is_last));
               end
            end
         end
         @(negedge clock);
      end
   end

   initial begin : request_side
      ltcq_item_type it;
      int           n;
      int           roll;
      int unsigned  first;
      int unsigned  pos;
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_APPEND;
      req_bus.node_index  = '0;
      req_bus.degree      = '0;
      req_bus.other_index = '0;
      foreach (op_count[i]) op_count[i] = 0;
      foreach (tree_bits[i]) tree_bits[i] = 1'b0;
      tree_bits[0] = 1'b1;
      nodes_in = 0;
      wr_pos = 2;

      // empty store, unknown op, widest node, full store, leaf, wrapped child indices
      add_row(make_row(OP_LIST,   6'd0,  6'd0,  6'd0,  1'b1, NOT_LOADED_RES));
      add_row(make_row(OP_TEST,   6'd63, 6'd63, 6'd63, 1'b1, NOT_LOADED_RES));
      add_row(make_row(OP_UNUSED, 6'd63, 6'd63, 6'd63, 1'b0, '0));
      add_row(make_row(OP_APPEND, 6'd63, 6'd63, 6'd63, 1'b1, OK_LAST_RES));
      add_row(make_row(OP_LIST,   6'd0,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_TEST,   6'd0,  6'd0,  6'd1,  1'b0, '0));
      add_row(make_row(OP_TEST,   6'd0,  6'd0,  6'd63, 1'b0, '0));
      add_row(make_row(OP_TEST,   6'd0,  6'd63, 6'd0,  1'b0, '0));
      add_row(make_row(OP_APPEND, 6'd0,  6'd63, 6'd0,  1'b1, FULL_RES));
      add_row(make_row(OP_APPEND, 6'd0,  6'd0,  6'd0,  1'b1, OK_LAST_RES));
      add_row(make_row(OP_LIST,   6'd1,  6'd0,  6'd0,  1'b1, OK_LAST_RES));
      add_row(make_row(OP_APPEND, 6'd0,  6'd3,  6'd0,  1'b1, OK_LAST_RES));
      add_row(make_row(OP_LIST,   6'd2,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_TEST,   6'd2,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_TEST,   6'd2,  6'd0,  6'd2,  1'b0, '0));
      add_row(make_row(OP_LIST,   6'd3,  6'd0,  6'd0,  1'b1, NOT_LOADED_RES));
      add_row(make_row(OP_TEST,   6'd3,  6'd0,  6'd0,  1'b1, NOT_LOADED_RES));
      add_row(make_row(OP_APPEND, 6'd0,  6'd1,  6'd0,  1'b1, OK_LAST_RES));
      add_row(make_row(OP_LIST,   6'd3,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_TEST,   6'd1,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_UNUSED, 6'd0,  6'd0,  6'd0,  1'b0, '0));
      add_row(make_row(OP_LIST,   6'd63, 6'd0,  6'd0,  1'b1, NOT_LOADED_RES));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 20;
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         idle_pct = (n < 100) ? 25 : (n < 200) ? 0 : 45;
         if (n == 40 && !hold_req && hold_left == 0) hold_req = 1'b1;
         if (n == 200) begin
            // quiet point: let every outstanding transfer drain
            req_bus.valid <= 1'b0;
            @(negedge clock);
            while (child_results_due.size() != 0) @(negedge clock);
         end
         it.operation   = OP_UNUSED;
         it.node_index  = $urandom_range(0, 63);
         it.degree      = $urandom_range(0, 63);
         it.other_index = $urandom_range(0, 63);
         roll = $urandom_range(0, 99);
         if (roll < 22) begin
            it.operation = OP_APPEND;
            roll = $urandom_range(0, 99);
            if (roll < 70) it.degree = $urandom_range(0, 2);
            else if (roll < 92) it.degree = $urandom_range(3, 8);
         end else if (roll < 93) begin
            it.operation = (roll < 62) ? OP_LIST : OP_TEST;
            if (nodes_in > 0 && $urandom_range(0, 99) < 88)
               it.node_index = $urandom_range(0, nodes_in - 1);
            if (it.operation == OP_TEST && $urandom_range(0, 99) < 70) begin
               locate_children(it.node_index, first, pos);
               it.other_index = FIELD_W'(first + $urandom_range(0, 4) - 1);
            end
         end
         send_item(it, 1'b0, '0);
         if (it.operation != OP_UNUSED) n++;
      end

      req_bus.valid <= 1'b0;
      while (child_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (child_results_due.size() != 0) fails++;

      $display("Covered %0d appends, %0d child lists, %0d relation tests, %0d ignored ops",
               op_count[OP_APPEND], op_count[OP_LIST], op_count[OP_TEST], op_count[OP_UNUSED]);
      $display("%0d transfers checked; tree grew to %0d nodes in %0d of %0d store bits",
               responses_seen, nodes_in, wr_pos, STORE_BITS);
      if (fails == 0) begin
         $display("[louds_tree_child_query] OK");
      end else begin
         $display("[louds_tree_child_query] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
